FILE: design/aib_pkg.sv
// ----------------------------------------------------------------------------
// aib_pkg: shared types and constants for the array insert buffer
// Capacity, index widths, operation and status codes, transaction structs.
// ----------------------------------------------------------------------------
package aib_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   // common width for comparing positions, indexes and the count
   localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;

   localparam logic [2:0] FUNC_INS_POS    = 3'd0;
   localparam logic [2:0] FUNC_INS_START  = 3'd1;
   localparam logic [2:0] FUNC_INS_END    = 3'd2;
   localparam logic [2:0] FUNC_INS_AFTER  = 3'd3;
   localparam logic [2:0] FUNC_INS_BEFORE = 3'd4;
   localparam logic [2:0] FUNC_READ       = 3'd5;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BADPOS   = 2'd1;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   typedef struct packed {
      logic [2:0]         func;
      logic [6:0]         position;
      logic signed [31:0] value;
      logic signed [31:0] target;
   } aib_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [6:0]         index_used;
      logic [6:0]         new_count;
      logic signed [31:0] read_word;
   } aib_rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } aib_cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_APPLY
   } aib_state_type;

endpackage

FILE: design/array_insert_buffer.sv
// ----------------------------------------------------------------------------
// array_insert_buffer: ordered word store with positional and keyed inserts
// Flow: each request is accepted, passes a compare state and then an apply state
// across the cell chain, and its response is registered; the next request can be
// taken in the apply state, which waits while the response is stalled.
// Reset: count cleared and response empty; stored words are not cleared.
// ----------------------------------------------------------------------------
module array_insert_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aib_pkg::aib_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aib_pkg::aib_rsp_type rsp_data
);
   import aib_pkg::*;

   aib_state_type      state_ff, state_in;
   aib_req_type        req_ff, req_in;
   aib_rsp_type        rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [31:0] read_ff, read_in;

   logic               req_fire;
   logic               apply_go;

   logic signed [31:0] words [CAPACITY];
   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] live_vec;
   aib_cell_cmd_type   cmds [CAPACITY];

   logic               found;
   logic [IDX_W-1:0]   found_idx;

   logic [CMP_W-1:0]   count_ext;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   idx;
   logic [1:0]         status;
   logic               do_ins;
   logic               ins_ok;

   assign req_fire  = req_valid && !req_stall;
   assign count_ext = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(req_ff.position);

   // cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left;
      if (i == 0) begin : g_head
         assign left = '0;
      end else begin : g_link
         assign left = words[i-1];
      end
      assign live_vec[i]  = (CMP_W'(i) < count_ext);
      assign cmds[i].load  = ins_ok && (CMP_W'(i) == idx);
      assign cmds[i].shift = ins_ok && (CMP_W'(i) > idx);

      aib_cell u_cell (
         .clock     (clock),
         .cmd       (cmds[i]),
         .left_word (left),
         .ins_word  (req_ff.value),
         .key       (req_ff.target),
         .word      (words[i]),
         .match     (match_vec[i])
      );
   end

   aib_first_match u_pick (
      .match (match_vec),
      .live  (live_vec),
      .found (found),
      .index (found_idx)
   );

   // decision logic, used in the apply cycle
   always_comb begin
      status = STATUS_OK;
      idx    = '0;
      do_ins = 1'b0;
      case (req_ff.func)
         FUNC_INS_POS: begin
            if (pos_ext > count_ext) begin
               status = STATUS_BADPOS;
            end else begin
               idx    = pos_ext;
               do_ins = 1'b1;
            end
         end
         FUNC_INS_START: begin
            do_ins = 1'b1;
         end
         FUNC_INS_END: begin
            idx    = count_ext;
            do_ins = 1'b1;
         end
         FUNC_INS_AFTER, FUNC_INS_BEFORE: begin
            if (!found) begin
               status = STATUS_NOTFOUND;
            end else begin
               idx    = (req_ff.func == FUNC_INS_AFTER) ?
                        CMP_W'(found_idx) + CMP_W'(1) : CMP_W'(found_idx);
               do_ins = 1'b1;
            end
         end
         FUNC_READ: begin
            if (pos_ext >= count_ext || pos_ext >= CMP_W'(CAPACITY)) begin
               status = STATUS_BADPOS;
            end else begin
               idx = pos_ext;
            end
         end
         default: begin
            status = STATUS_BADPOS;
         end
      endcase
      if (do_ins && count_ext == CMP_W'(CAPACITY)) begin
         status = STATUS_FULL;
      end
      if (status != STATUS_OK) begin
         idx = '0;
      end
   end

   assign ins_ok = apply_go && do_ins && (status == STATUS_OK);

   // state machine: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_go) state_in = req_fire ? ST_CMP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state machine: outputs
   always_comb begin
      apply_go  = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_CMP: begin
            req_stall = 1'b1;
         end
         ST_APPLY: begin
            apply_go  = !rsp_valid_ff || !rsp_stall;
            req_stall = !apply_go;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      req_in   = req_fire ? req_data : req_ff;
      read_in  = (state_ff == ST_CMP) ? words[pos_ext[IDX_W-1:0]] : read_ff;
      count_in = ins_ok ? count_ff + CNT_W'(1) : count_ff;

      rsp_in = rsp_ff;
      if (apply_go) begin
         rsp_in.status     = status;
         rsp_in.index_used = idx[6:0];
         rsp_in.new_count  = count_in[6:0];
         rsp_in.read_word  = (req_ff.func == FUNC_READ && status == STATUS_OK) ?
                             read_ff : '0;
      end
      rsp_valid_in = apply_go || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      read_ff <= read_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: design/aib_cell.sv
// ----------------------------------------------------------------------------
// aib_cell: one storage cell of the insert chain
// Holds one word, takes its left neighbor's word on a shift, the new word on
// a load, and registers an equality compare against the search key.
// ----------------------------------------------------------------------------
module aib_cell (
   input  logic                      clock,
   input  aib_pkg::aib_cell_cmd_type cmd,
   input  logic signed [31:0]        left_word,
   input  logic signed [31:0]        ins_word,
   input  logic signed [31:0]        key,
   output logic signed [31:0]        word,
   output logic                      match
);
   import aib_pkg::*;

   logic signed [31:0] word_ff, word_in;
   logic               match_ff, match_in;

   always_comb begin
      word_in = word_ff;
      if (cmd.load) begin
         word_in = ins_word;
      end else if (cmd.shift) begin
         word_in = left_word;
      end
      match_in = (word_ff == key);
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      match_ff <= match_in;
   end

   assign word  = word_ff;
   assign match = match_ff;

endmodule

FILE: design/aib_first_match.sv
// ----------------------------------------------------------------------------
// aib_first_match: priority pick of the lowest valid matching cell
// ----------------------------------------------------------------------------
module aib_first_match (
   input  logic [aib_pkg::CAPACITY-1:0] match,
   input  logic [aib_pkg::CAPACITY-1:0] live,
   output logic                         found,
   output logic [aib_pkg::IDX_W-1:0]    index
);
   import aib_pkg::*;

   logic [CAPACITY-1:0] hit;

   always_comb begin
      hit   = match & live;
      found = |hit;
      index = '0;
      // scan downward so the lowest hit wins
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hit[i]) begin
            index = IDX_W'(i);
         end
      end
   end

endmodule

FILE: bench/array_insert_buffer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_insert_buffer_test: self-checking bench for the array insert buffer
// Drives positional, keyed, start and end inserts plus reads, tracks the ordered
// store in a local model and checks every response field in order. Runs
// under several sender/receiver idle mixes, one long response hold-off, and
// a full store.
// ----------------------------------------------------------------------------
module array_insert_buffer_test;
   import aib_pkg::*;

   // func codes the block does not implement
   localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   aib_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   aib_rsp_type rsp_data;

   // local copy of the store
   logic signed [31:0] model_words [CAPACITY];
   int unsigned        model_count = 0;

   aib_rsp_type pending_outcomes [$];
   int          fail_count = 0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int stall_hold_cycles = 0;

   array_insert_buffer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("array_insert_buffer_test failed");
      $finish;
   end

   // ---------------------------------------------------------------- model
   function automatic logic [1:0] shift_in_word(input int unsigned slot,
                                                input logic signed [31:0] word);
      int unsigned i;
      if (model_count >= CAPACITY) return STATUS_FULL;
      for (i = model_count; i > slot; i--) model_words[i] = model_words[i - 1];
      model_words[slot] = word;
      model_count++;
      return STATUS_OK;
   endfunction

   function automatic aib_rsp_type apply_buffer_op(input aib_req_type req);
      aib_rsp_type        outcome;
      int unsigned        slot;
      int                 hit;
      int unsigned        i;
      logic [1:0]         st;
      logic signed [31:0] word_out;
      st = STATUS_OK;
      slot = 0;
      hit = -1;
      word_out = '0;
      case (req.func)
         FUNC_INS_POS: begin
            if (req.position > model_count) begin
               st = STATUS_BADPOS;
            end else begin
               slot = req.position;
               st = shift_in_word(slot, req.value);
            end
         end
         FUNC_INS_START: begin
            st = shift_in_word(0, req.value);
         end
         FUNC_INS_END: begin
            slot = model_count;
            st = shift_in_word(slot, req.value);
         end
         FUNC_INS_AFTER, FUNC_INS_BEFORE: begin
            // first match wins
            for (i = 0; i < model_count; i++)
               if (hit < 0 && model_words[i] == req.target) hit = i;
            if (hit < 0) begin
               st = STATUS_NOTFOUND;
            end else begin
               slot = (req.func == FUNC_INS_AFTER) ? hit + 1 : hit;
               st = shift_in_word(slot, req.value);
            end
         end
         FUNC_READ: begin
            if (req.position >= model_count) begin
               st = STATUS_BADPOS;
            end else begin
               slot = req.position;
               word_out = model_words[slot];
            end
         end
         default: begin
            st = STATUS_BADPOS;
         end
      endcase
      if (st != STATUS_OK) begin
         slot = 0;
         word_out = '0;
      end
      outcome.status = st;
      outcome.index_used = slot[6:0];
      outcome.new_count = model_count[6:0];
      outcome.read_word = word_out;
      return outcome;
   endfunction

   // ------------------------------------------------------------- stimulus
   function automatic aib_req_type make_request(input logic [2:0] func,
                                                input logic [6:0] position,
                                                input logic signed [31:0] value,
                                                input logic signed [31:0] target);
      aib_req_type req;
      req.func = func;
      req.position = position;
      req.value = value;
      req.target = target;
      return req;
   endfunction

   // small values repeat often so keyed inserts see duplicates
   function automatic logic signed [31:0] draw_word();
      case ($urandom_range(3))
         0: return 32'($urandom_range(3));
         1: begin
            case ($urandom_range(3))
               0: return WORD_MIN;
               1: return WORD_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic aib_req_type draw_request();
      aib_req_type req;
      int          pick;
      pick = $urandom_range(99);
      req = make_request(FUNC_READ, 7'($urandom_range(127)), draw_word(), draw_word());
      if (pick < 3) begin
         req.func = $urandom_range(1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      end else if (pick < 11) begin
         req.func = 3'($urandom_range(FUNC_INS_BEFORE, FUNC_INS_POS));
         if (req.func == FUNC_INS_POS && $urandom_range(3) != 0)
            req.position = 7'($urandom_range(model_count));
         if ((req.func == FUNC_INS_AFTER || req.func == FUNC_INS_BEFORE) &&
             model_count > 0 && $urandom_range(3) != 0)
            req.target = model_words[$urandom_range(model_count - 1)];
      end else if (model_count > 0 && $urandom_range(3) != 0) begin
         req.position = 7'($urandom_range(model_count - 1));
      end
      return req;
   endfunction

   // offer one transaction, hold it until accepted, then log its outcome
   task automatic send_request(input aib_req_type req);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_outcomes.push_back(apply_buffer_op(req));
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // --------------------------------------------------------- receiver side
   always @(negedge clock) begin
      if (stall_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         stall_hold_cycles = stall_hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      aib_rsp_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("response with no transaction outstanding: %p", rsp_data);
            fail_count++;
         end else begin
            expected = pending_outcomes.pop_front();
            if (rsp_data.status !== expected.status) begin
               $error("status mismatch: expected %0d, got %0d",
                      expected.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.index_used !== expected.index_used) begin
               $error("index_used mismatch: expected %0d, got %0d",
                      expected.index_used, rsp_data.index_used);
               fail_count++;
            end
            if (rsp_data.new_count !== expected.new_count) begin
               $error("new_count mismatch: expected %0d, got %0d",
                      expected.new_count, rsp_data.new_count);
               fail_count++;
            end
            if (rsp_data.read_word !== expected.read_word) begin
               $error("read_word mismatch: expected %0d, got %0d",
                      expected.read_word, rsp_data.read_word);
               fail_count++;
            end
         end
      end
   end

   // ----------------------------------------------------------------- tests
   task automatic test_directed_cases();
      set_idling(0, 0);
      send_request(make_request(FUNC_READ, 7'd0, '0, '0));            // empty store
      send_request(make_request(FUNC_INS_AFTER, 7'd0, 32'sd9, '0));   // nothing to match
      send_request(make_request(FUNC_INS_POS, 7'd1, 32'sd9, '0));     // past the end
      send_request(make_request(FUNC_INS_POS, 7'd0, WORD_MIN, '0));
      send_request(make_request(FUNC_INS_END, 7'd0, WORD_MAX, '0));
      send_request(make_request(FUNC_INS_START, 7'h7F, '1, '0));
      send_request(make_request(FUNC_INS_POS, 7'(model_count), '0, '0));
      send_request(make_request(FUNC_INS_POS, 7'd2, 32'sd5, '0));
      send_request(make_request(FUNC_INS_AFTER, 7'd0, 32'sd5, WORD_MAX));
      // two fives stored now: keyed inserts must pick the lower one
      send_request(make_request(FUNC_INS_BEFORE, 7'd0, 32'sd6, 32'sd5));
      send_request(make_request(FUNC_INS_AFTER, 7'd0, 32'sd7, 32'sd5));
      send_request(make_request(FUNC_INS_BEFORE, 7'd0, 32'sd8, 32'sd1234));
      send_request(make_request(FUNC_INS_BEFORE, 7'd0, WORD_MIN, WORD_MIN));
      send_request(make_request(FUNC_INS_AFTER, 7'd0, WORD_MAX, '0));  // after last
      send_request(make_request(FUNC_SPARE_6, 7'd0, 32'sd1, 32'sd1));
      send_request(make_request(FUNC_SPARE_7, 7'h7F, '1, '1));
      send_request(make_request(FUNC_READ, 7'd0, '0, '0));
      send_request(make_request(FUNC_READ, 7'(model_count - 1), '0, '0));
      send_request(make_request(FUNC_READ, 7'(model_count), '0, '0));
      send_request(make_request(FUNC_READ, 7'd64, '0, '0));
      send_request(make_request(FUNC_READ, 7'h7F, '0, '0));
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input int items);
      set_idling(send_pct, stall_pct);
      repeat (items) send_request(draw_request());
   endtask

   // receiver holds off long enough for the block to back up into its input
   task automatic test_stall_backpressure();
      set_idling(0, 0);
      stall_hold_cycles = 80;
      repeat (30) send_request(draw_request());
   endtask

   task automatic test_full_store();
      logic signed [31:0] absent;
      bit                 present;
      set_idling(26, 26);
      while (model_count < CAPACITY)
         send_request(make_request($urandom_range(1) ? FUNC_INS_START : FUNC_INS_END,
                                   7'($urandom_range(127)), draw_word(), '0));
      do begin
         absent = $urandom();
         present = 0;
         foreach (model_words[i]) if (model_words[i] == absent) present = 1;
      end while (present);
      send_request(make_request(FUNC_INS_POS, 7'd0, 32'sd1, '0));
      send_request(make_request(FUNC_INS_POS, 7'(CAPACITY), 32'sd1, '0));
      send_request(make_request(FUNC_INS_POS, 7'(CAPACITY + 1), 32'sd1, '0));
      send_request(make_request(FUNC_INS_START, 7'd0, 32'sd1, '0));
      send_request(make_request(FUNC_INS_END, 7'd0, 32'sd1, '0));
      send_request(make_request(FUNC_INS_AFTER, 7'd0, 32'sd1, model_words[CAPACITY - 1]));
      send_request(make_request(FUNC_INS_BEFORE, 7'd0, 32'sd1, model_words[0]));
      send_request(make_request(FUNC_INS_BEFORE, 7'd0, 32'sd1, absent));
      send_request(make_request(FUNC_READ, 7'(CAPACITY - 1), '0, '0));
      send_request(make_request(FUNC_READ, 7'(CAPACITY), '0, '0));
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(0, 0, 200);
      test_random_traffic(53, 0, 250);
      test_stall_backpressure();
      test_random_traffic(0, 53, 250);
      test_random_traffic(26, 26, 250);
      test_random_traffic(0, 0, 150);
      test_full_store();
      test_random_traffic(26, 26, 150);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      // catch any stray responses before the verdict
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("array_insert_buffer_test passed");
      end else begin
         $display("array_insert_buffer_test failed");
      end
      $finish;
   end

endmodule
